@@ sv/cci_pkg.sv @@
// shared widths, stage indexes and pipeline item type for the circle collision impulse block
`default_nettype none
package cci_pkg;

   localparam int CW     = 24;
   localparam int MW     = CW;
   localparam int PW     = $clog2(CW);
   localparam int NB     = 16;
   localparam int NRM    = 14;
   localparam int EW     = 9;
   localparam int ONE_Q8 = 256;
   localparam int MAW    = 16;

   localparam int SQW = 2 * NB + 2;
   localparam int RTW = NB + 1;
   localparam int SRW = RTW + 4;
   localparam int DRW = RTW + 1;
   localparam int QW  = NRM + 1;
   localparam int NDW = NB + QW;
   localparam int WQ  = MAW + 1;
   localparam int WNW = 2 * MAW + 1;

   localparam int VRW = CW + 17;
   localparam int GPW = VRW + 10;
   localparam int GW  = GPW - 7;
   localparam int CCW = GW - 13;
   localparam int PAW = CCW + WQ;
   localparam int CAW = PAW - 15;
   localparam int QPW = CAW + NB + 1;
   localparam int RSW = QPW - 11;

   localparam int ST_IN   = 0;
   localparam int ST_NORM = 1;
   localparam int ST_SQ   = 2;
   localparam int ST_RT0  = 3;
   localparam int ST_DV0  = ST_RT0 + RTW;
   localparam int ST_PR   = ST_DV0 + QW;
   localparam int ST_VR   = ST_PR + 1;
   localparam int ST_GP   = ST_VR + 1;
   localparam int ST_G    = ST_GP + 1;
   localparam int ST_C    = ST_G + 1;
   localparam int ST_PA   = ST_C + 1;
   localparam int ST_CA   = ST_PA + 1;
   localparam int ST_Q    = ST_CA + 1;
   localparam int ST_OUT  = ST_Q + 1;
   localparam int NST     = ST_OUT + 1;

   typedef struct packed {
      logic signed [CW-1:0]  avx;
      logic signed [CW-1:0]  avy;
      logic signed [CW-1:0]  bvx;
      logic signed [CW-1:0]  bvy;
      logic signed [CW:0]    rvx;
      logic signed [CW:0]    rvy;
      logic                  sx;
      logic                  sy;
      logic                  nz;
      logic [EW-1:0]         e;
      logic [MW-1:0]         mx;
      logic [MW-1:0]         my;
      logic [NB-1:0]         nmx;
      logic [NB-1:0]         nmy;
      logic [MAW-1:0]        ma;
      logic [MAW-1:0]        mb;
      logic [MAW:0]          msum;
      logic [WNW-1:0]        wan;
      logic [WNW-1:0]        wbn;
      logic [DRW-1:0]        warem;
      logic [DRW-1:0]        wbrem;
      logic [WQ-1:0]         wa;
      logic [WQ-1:0]         wb;
      logic [SQW-1:0]        rad;
      logic [SRW-1:0]        srem;
      logic [RTW-1:0]        root;
      logic [NDW-1:0]        uxn;
      logic [NDW-1:0]        uyn;
      logic [DRW-1:0]        uxrem;
      logic [DRW-1:0]        uyrem;
      logic [QW-1:0]         ux;
      logic [QW-1:0]         uy;
      logic signed [NB-1:0]  nx;
      logic signed [NB-1:0]  ny;
      logic signed [VRW-1:0] px;
      logic signed [VRW-1:0] py;
      logic [VRW-1:0]        nv;
      logic                  applied;
      logic [GPW-1:0]        gp;
      logic [GW-1:0]         g;
      logic [CCW-1:0]        cc;
      logic [PAW-1:0]        pa;
      logic [PAW-1:0]        pb;
      logic [CAW-1:0]        ca;
      logic [CAW-1:0]        cb;
      logic signed [QPW-1:0] qax;
      logic signed [QPW-1:0] qay;
      logic signed [QPW-1:0] qbx;
      logic signed [QPW-1:0] qby;
      logic signed [CW-1:0]  nax;
      logic signed [CW-1:0]  nay;
      logic signed [CW-1:0]  nbx;
      logic signed [CW-1:0]  nby;
      logic                  satf;
   } item_type;

endpackage
`default_nettype wire

@@ sv/circle_collision_impulse.sv @@
// circle pair collision response: fully pipelined impulse computation
//
// One request enters per clock cycle and busy never rises. Each result leaves,
// in request order, on a one-cycle rsp_valid strobe; the receiver must take it
// then. The depth comes from the bit-per-stage square root of the normalized
// contact distance (17 stages, which also carry the two mass-weight dividers)
// followed by the bit-per-stage normal dividers (15 stages) and the multiply
// and round stages of the impulse.
`default_nettype none
module circle_collision_impulse import cci_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic signed [CW-1:0] req_a_pos_x,
   input  logic signed [CW-1:0] req_a_pos_y,
   input  logic signed [CW-1:0] req_b_pos_x,
   input  logic signed [CW-1:0] req_b_pos_y,
   input  logic signed [CW-1:0] req_a_vel_x,
   input  logic signed [CW-1:0] req_a_vel_y,
   input  logic signed [CW-1:0] req_b_vel_x,
   input  logic signed [CW-1:0] req_b_vel_y,
   input  logic [MAW-1:0]       req_a_mass,
   input  logic [MAW-1:0]       req_b_mass,
   input  logic [EW-1:0]        req_a_restitution,
   input  logic [EW-1:0]        req_b_restitution,
   output logic                 rsp_valid,
   output logic signed [CW-1:0] rsp_new_a_vel_x,
   output logic signed [CW-1:0] rsp_new_a_vel_y,
   output logic signed [CW-1:0] rsp_new_b_vel_x,
   output logic signed [CW-1:0] rsp_new_b_vel_y,
   output logic                 rsp_impulse_applied,
   output logic                 rsp_saturated
);

   localparam logic signed [RSW-1:0] HI = RSW'((64'sd1 <<< (CW - 1)) - 64'sd1);
   localparam logic signed [RSW-1:0] LO = -HI - RSW'(1);

   item_type       pipe_ff [NST];
   item_type       pipe_in [NST];
   logic [NST-1:0] vld_ff;
   logic [NST-1:0] vld_in;

   function automatic logic signed [QPW-13:0] rnd_q(input logic signed [QPW-1:0] q);
      logic [QPW-1:0]          m;
      logic [QPW-1:0]          s;
      logic signed [QPW-13:0]  t;
      m = q[QPW-1] ? QPW'(-q) : QPW'(q);
      s = (m + (QPW'(1) << (NRM - 1))) >> NRM;
      t = signed'((QPW-12)'(s));
      rnd_q = q[QPW-1] ? -t : t;
   endfunction

   function automatic logic signed [CW-1:0] clip(input logic signed [RSW-1:0] v);
      if (v > HI) begin
         clip = HI[CW-1:0];
      end else if (v < LO) begin
         clip = LO[CW-1:0];
      end else begin
         clip = v[CW-1:0];
      end
   endfunction

   function automatic logic over(input logic signed [RSW-1:0] v);
      over = (v > HI) || (v < LO);
   endfunction

   assign busy = 1'b0;

   // request capture: differences, magnitudes, clamps
   always_comb begin
      item_type          it;
      logic signed [CW:0] dx;
      logic signed [CW:0] dy;
      logic signed [CW:0] rx;
      logic signed [CW:0] ry;
      logic [MAW-1:0]    ma;
      logic [MAW-1:0]    mb;
      logic [EW-1:0]     ea;
      logic [EW-1:0]     eb;
      it = '0;
      dx = (CW+1)'(req_b_pos_x) - (CW+1)'(req_a_pos_x);
      dy = (CW+1)'(req_b_pos_y) - (CW+1)'(req_a_pos_y);
      rx = (CW+1)'(req_b_vel_x) - (CW+1)'(req_a_vel_x);
      ry = (CW+1)'(req_b_vel_y) - (CW+1)'(req_a_vel_y);
      ma = (req_a_mass == '0) ? MAW'(1) : req_a_mass;
      mb = (req_b_mass == '0) ? MAW'(1) : req_b_mass;
      ea = (req_a_restitution > EW'(ONE_Q8)) ? EW'(ONE_Q8) : req_a_restitution;
      eb = (req_b_restitution > EW'(ONE_Q8)) ? EW'(ONE_Q8) : req_b_restitution;
      it.avx  = req_a_vel_x;
      it.avy  = req_a_vel_y;
      it.bvx  = req_b_vel_x;
      it.bvy  = req_b_vel_y;
      it.sx   = dx[CW];
      it.sy   = dy[CW];
      it.nz   = (dx != '0) || (dy != '0);
      it.mx   = dx[CW] ? MW'(-dx) : MW'(dx);
      it.my   = dy[CW] ? MW'(-dy) : MW'(dy);
      it.rvx  = dx[CW] ? -rx : rx;
      it.rvy  = dy[CW] ? -ry : ry;
      it.ma   = ma;
      it.mb   = mb;
      it.msum = (MAW+1)'(ma) + (MAW+1)'(mb);
      it.e    = (ea < eb) ? ea : eb;
      pipe_in[ST_IN] = it;
   end

   // normalize so the larger magnitude has its top bit at NB-1; form the mass-weight numerators
   always_comb begin
      item_type      it;
      logic [MW-1:0] top;
      logic [PW-1:0] p;
      logic [MW-1:0] sx;
      logic [MW-1:0] sy;
      it  = pipe_ff[ST_IN];
      top = (it.mx > it.my) ? it.mx : it.my;
      p   = '0;
      for (int i = 0; i < CW; i++) begin
         if (top[i]) p = PW'(i);
      end
      if (p >= PW'(NB - 1)) begin
         sx = it.mx >> (p - PW'(NB - 1));
         sy = it.my >> (p - PW'(NB - 1));
      end else begin
         sx = it.mx << (PW'(NB - 1) - p);
         sy = it.my << (PW'(NB - 1) - p);
      end
      it.nmx = sx[NB-1:0];
      it.nmy = sy[NB-1:0];
      it.wan = WNW'({it.mb, MAW'(0)}) + WNW'(it.msum >> 1);
      it.wbn = WNW'({it.ma, MAW'(0)}) + WNW'(it.msum >> 1);
      pipe_in[ST_NORM] = it;
   end

   // squared length and divider setup
   always_comb begin
      item_type        it;
      logic [2*NB-1:0] qx;
      logic [2*NB-1:0] qy;
      it       = pipe_ff[ST_NORM];
      qx       = it.nmx * it.nmx;
      qy       = it.nmy * it.nmy;
      it.rad   = SQW'(qx) + SQW'(qy);
      it.srem  = '0;
      it.root  = '0;
      it.warem = DRW'(it.wan[WNW-1:WQ]);
      it.wbrem = DRW'(it.wbn[WNW-1:WQ]);
      it.wa    = '0;
      it.wb    = '0;
      pipe_in[ST_SQ] = it;
   end

   // square root and mass weights, one result bit per stage
   for (genvar j = 0; j < RTW; j++) begin : g_root
      always_comb begin
         item_type       it;
         logic [SRW-1:0] rn;
         logic [SRW-1:0] trial;
         logic [DRW-1:0] ra;
         logic [DRW-1:0] rb;
         it    = pipe_ff[ST_RT0+j-1];
         rn    = {it.srem[SRW-3:0], it.rad[SQW-1-2*j -: 2]};
         trial = SRW'({it.root, 2'b01});
         if (rn >= trial) begin
            it.srem = rn - trial;
            it.root = {it.root[RTW-2:0], 1'b1};
         end else begin
            it.srem = rn;
            it.root = {it.root[RTW-2:0], 1'b0};
         end
         ra = {it.warem[DRW-2:0], it.wan[WQ-1-j]};
         rb = {it.wbrem[DRW-2:0], it.wbn[WQ-1-j]};
         if (ra >= DRW'(it.msum)) begin
            it.warem = ra - DRW'(it.msum);
            it.wa    = {it.wa[WQ-2:0], 1'b1};
         end else begin
            it.warem = ra;
            it.wa    = {it.wa[WQ-2:0], 1'b0};
         end
         if (rb >= DRW'(it.msum)) begin
            it.wbrem = rb - DRW'(it.msum);
            it.wb    = {it.wb[WQ-2:0], 1'b1};
         end else begin
            it.wbrem = rb;
            it.wb    = {it.wb[WQ-2:0], 1'b0};
         end
         pipe_in[ST_RT0+j] = it;
      end
   end

   // unit normal magnitudes, one quotient bit per stage
   for (genvar j = 0; j < QW; j++) begin : g_div
      always_comb begin
         item_type       it;
         logic [DRW-1:0] len;
         logic [DRW-1:0] rx;
         logic [DRW-1:0] ry;
         it  = pipe_ff[ST_DV0+j-1];
         len = DRW'(it.root);
         if (j == 0) begin
            it.uxn   = (NDW'(it.nmx) << NRM) + NDW'(it.root >> 1);
            it.uyn   = (NDW'(it.nmy) << NRM) + NDW'(it.root >> 1);
            it.uxrem = DRW'(it.uxn[NDW-1:QW]);
            it.uyrem = DRW'(it.uyn[NDW-1:QW]);
            it.ux    = '0;
            it.uy    = '0;
         end
         rx = {it.uxrem[DRW-2:0], it.uxn[QW-1-j]};
         ry = {it.uyrem[DRW-2:0], it.uyn[QW-1-j]};
         if (rx >= len) begin
            it.uxrem = rx - len;
            it.ux    = {it.ux[QW-2:0], 1'b1};
         end else begin
            it.uxrem = rx;
            it.ux    = {it.ux[QW-2:0], 1'b0};
         end
         if (ry >= len) begin
            it.uyrem = ry - len;
            it.uy    = {it.uy[QW-2:0], 1'b1};
         end else begin
            it.uyrem = ry;
            it.uy    = {it.uy[QW-2:0], 1'b0};
         end
         pipe_in[ST_DV0+j] = it;
      end
   end

   // signed normal and relative speed products
   always_comb begin
      item_type             it;
      logic signed [NB-1:0] ux;
      logic signed [NB-1:0] uy;
      it    = pipe_ff[ST_PR-1];
      ux    = signed'(NB'(it.ux));
      uy    = signed'(NB'(it.uy));
      it.nx = it.sx ? -ux : ux;
      it.ny = it.sy ? -uy : uy;
      it.px = it.rvx * ux;
      it.py = it.rvy * uy;
      pipe_in[ST_PR] = it;
   end

   always_comb begin
      item_type              it;
      logic signed [VRW-1:0] vr;
      it         = pipe_ff[ST_PR];
      vr         = it.px + it.py;
      it.applied = it.nz && (vr <= 0);
      it.nv      = VRW'(-vr);
      pipe_in[ST_VR] = it;
   end

   always_comb begin
      item_type  it;
      logic [9:0] fac;
      it    = pipe_ff[ST_VR];
      fac   = 10'(ONE_Q8) + 10'(it.e);
      it.gp = it.nv * fac;
      pipe_in[ST_GP] = it;
   end

   always_comb begin
      item_type     it;
      logic [GPW:0] t;
      it   = pipe_ff[ST_GP];
      t    = (GPW+1)'(it.gp) + (GPW+1)'(128);
      it.g = t[GPW:8];
      pipe_in[ST_G] = it;
   end

   always_comb begin
      item_type    it;
      logic [GW:0] t;
      it    = pipe_ff[ST_G];
      t     = (GW+1)'(it.g) + ((GW+1)'(1) << (NRM - 1));
      it.cc = t[GW:NRM];
      pipe_in[ST_C] = it;
   end

   always_comb begin
      item_type it;
      it    = pipe_ff[ST_C];
      it.pa = PAW'(it.cc) * PAW'(it.wa);
      it.pb = PAW'(it.cc) * PAW'(it.wb);
      pipe_in[ST_PA] = it;
   end

   always_comb begin
      item_type     it;
      logic [PAW:0] ta;
      logic [PAW:0] tb;
      it    = pipe_ff[ST_PA];
      ta    = (PAW+1)'(it.pa) + ((PAW+1)'(1) << 15);
      tb    = (PAW+1)'(it.pb) + ((PAW+1)'(1) << 15);
      it.ca = ta[PAW:16];
      it.cb = tb[PAW:16];
      pipe_in[ST_CA] = it;
   end

   always_comb begin
      item_type              it;
      logic signed [CAW:0]   sa;
      logic signed [CAW:0]   sb;
      it     = pipe_ff[ST_CA];
      sa     = signed'({1'b0, it.ca});
      sb     = signed'({1'b0, it.cb});
      it.qax = sa * it.nx;
      it.qay = sa * it.ny;
      it.qbx = sb * it.nx;
      it.qby = sb * it.ny;
      pipe_in[ST_Q] = it;
   end

   // velocity update and saturation
   always_comb begin
      item_type              it;
      logic signed [RSW-1:0] rax;
      logic signed [RSW-1:0] ray;
      logic signed [RSW-1:0] rbx;
      logic signed [RSW-1:0] rby;
      it  = pipe_ff[ST_Q];
      rax = RSW'(it.avx) - RSW'(rnd_q(it.qax));
      ray = RSW'(it.avy) - RSW'(rnd_q(it.qay));
      rbx = RSW'(it.bvx) + RSW'(rnd_q(it.qbx));
      rby = RSW'(it.bvy) + RSW'(rnd_q(it.qby));
      if (it.applied) begin
         it.nax  = clip(rax);
         it.nay  = clip(ray);
         it.nbx  = clip(rbx);
         it.nby  = clip(rby);
         it.satf = over(rax) || over(ray) || over(rbx) || over(rby);
      end else begin
         it.nax  = it.avx;
         it.nay  = it.avy;
         it.nbx  = it.bvx;
         it.nby  = it.bvy;
         it.satf = 1'b0;
      end
      pipe_in[ST_OUT] = it;
   end

   assign vld_in = {vld_ff[NST-2:0], start & ~busy};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      pipe_ff <= pipe_in;
   end

   assign rsp_valid           = vld_ff[ST_OUT];
   assign rsp_new_a_vel_x     = pipe_ff[ST_OUT].nax;
   assign rsp_new_a_vel_y     = pipe_ff[ST_OUT].nay;
   assign rsp_new_b_vel_x     = pipe_ff[ST_OUT].nbx;
   assign rsp_new_b_vel_y     = pipe_ff[ST_OUT].nby;
   assign rsp_impulse_applied = pipe_ff[ST_OUT].applied;
   assign rsp_saturated       = pipe_ff[ST_OUT].satf;

endmodule
`default_nettype wire

@@ sv/cci_checker.sv @@
// port-level checks for the circle collision impulse block and their bind
`default_nettype none
module cci_checker import cci_pkg::*; (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 start,
   input wire logic                 busy,
   input wire logic signed [CW-1:0] req_a_pos_x,
   input wire logic signed [CW-1:0] req_a_pos_y,
   input wire logic signed [CW-1:0] req_b_pos_x,
   input wire logic signed [CW-1:0] req_b_pos_y,
   input wire logic signed [CW-1:0] req_a_vel_x,
   input wire logic signed [CW-1:0] req_a_vel_y,
   input wire logic signed [CW-1:0] req_b_vel_x,
   input wire logic signed [CW-1:0] req_b_vel_y,
   input wire logic                 rsp_valid,
   input wire logic signed [CW-1:0] rsp_new_a_vel_x,
   input wire logic signed [CW-1:0] rsp_new_a_vel_y,
   input wire logic signed [CW-1:0] rsp_new_b_vel_x,
   input wire logic signed [CW-1:0] rsp_new_b_vel_y,
   input wire logic                 rsp_impulse_applied,
   input wire logic                 rsp_saturated
);

   // every response traces back to a request a fixed latency earlier
   a_resp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, NST))
      else $error("response without request");

   a_nosat_passthru: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_impulse_applied |-> !rsp_saturated)
      else $error("saturation flagged without impulse");

   a_passthru_vel: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_impulse_applied |->
         rsp_new_a_vel_x == $past(req_a_vel_x, NST) &&
         rsp_new_a_vel_y == $past(req_a_vel_y, NST) &&
         rsp_new_b_vel_x == $past(req_b_vel_x, NST) &&
         rsp_new_b_vel_y == $past(req_b_vel_y, NST))
      else $error("velocities changed without impulse");

   a_coincident: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && $past(req_a_pos_x == req_b_pos_x && req_a_pos_y == req_b_pos_y, NST)
         |-> !rsp_impulse_applied)
      else $error("impulse applied for coincident centers");

endmodule

bind circle_collision_impulse cci_checker u_cci_checker (.*);
`default_nettype wire

@@ bench/circle_collision_impulse_tb.sv @@
// testbench for circle_collision_impulse: directed and random requests checked against a built-in impulse predictor
`timescale 1ns / 1ps
`default_nettype none
module circle_collision_impulse_tb;
   import cci_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 60;

   typedef struct {
      logic signed [CW-1:0] apx, apy, bpx, bpy, avx, avy, bvx, bvy;
      logic [MAW-1:0]       ma, mb;
      logic [EW-1:0]        ea, eb;
   } pair_type;

   typedef struct {
      logic signed [CW-1:0] nax, nay, nbx, nby;
      logic                 applied, satf;
   } velocities_type;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic signed [CW-1:0] req_a_pos_x = 0, req_a_pos_y = 0, req_b_pos_x = 0, req_b_pos_y = 0;
   logic signed [CW-1:0] req_a_vel_x = 0, req_a_vel_y = 0, req_b_vel_x = 0, req_b_vel_y = 0;
   logic [MAW-1:0] req_a_mass = 1, req_b_mass = 1;
   logic [EW-1:0]  req_a_restitution = 0, req_b_restitution = 0;
   logic rsp_valid;
   logic signed [CW-1:0] rsp_new_a_vel_x, rsp_new_a_vel_y, rsp_new_b_vel_x, rsp_new_b_vel_y;
   logic rsp_impulse_applied, rsp_saturated;

   velocities_type pending_velocities[$];
   int  failures = 0;
   int  quiet_cycles = 0;
   int  sender_idle_pct = 0;

   always #2 clock = ~clock;

   circle_collision_impulse dut (.*);

   function automatic longint round_shift(input longint x, input int s);
      longint half;
      half = longint'(1) << (s - 1);
      if (x >= 0) return (x + half) >>> s;
      return -((-x + half) >>> s);
   endfunction

   function automatic longint int_sqrt(input longint v);
      longint r, b;
      r = 0;
      b = longint'(1) << 40;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic longint clamp_velocity(input longint v, inout logic flag);
      longint hi, lo;
      hi = (longint'(1) << (CW - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) begin
         flag = 1;
         return hi;
      end
      if (v < lo) begin
         flag = 1;
         return lo;
      end
      return v;
   endfunction

   function automatic velocities_type predict_impulse(input pair_type p);
      velocities_type o;
      longint dx, dy, mx, my, top, len, nx, ny, vr, e, ma, mb, ms, wa, wb, g, c, ca, cb;
      o.nax = p.avx; o.nay = p.avy; o.nbx = p.bvx; o.nby = p.bvy;
      o.applied = 0; o.satf = 0;
      ma = (p.ma == 0) ? longint'(1) : longint'(p.ma);
      mb = (p.mb == 0) ? longint'(1) : longint'(p.mb);
      e  = (p.ea < p.eb) ? longint'(p.ea) : longint'(p.eb);
      if (e > ONE_Q8) e = ONE_Q8;
      dx = longint'(p.bpx) - longint'(p.apx);
      dy = longint'(p.bpy) - longint'(p.apy);
      if (dx == 0 && dy == 0) return o;
      mx = dx < 0 ? -dx : dx;
      my = dy < 0 ? -dy : dy;
      top = mx > my ? mx : my;
      while (top >= 65536) begin mx = mx >> 1; my = my >> 1; top = top >> 1; end
      while (top < 32768) begin mx = mx << 1; my = my << 1; top = top << 1; end
      len = int_sqrt(mx * mx + my * my);
      nx = ((mx << NRM) + (len >> 1)) / len;
      ny = ((my << NRM) + (len >> 1)) / len;
      if (dx < 0) nx = -nx;
      if (dy < 0) ny = -ny;
      vr = (longint'(p.bvx) - longint'(p.avx)) * nx + (longint'(p.bvy) - longint'(p.avy)) * ny;
      if (vr > 0) return o;
      ms = ma + mb;
      wa = ((mb << 16) + (ms >> 1)) / ms;
      wb = ((ma << 16) + (ms >> 1)) / ms;
      g  = round_shift(-vr * (ONE_Q8 + e), 8);
      c  = round_shift(g, NRM);
      ca = round_shift(c * wa, 16);
      cb = round_shift(c * wb, 16);
      o.applied = 1;
      o.nax = CW'(clamp_velocity(longint'(p.avx) - round_shift(ca * nx, NRM), o.satf));
      o.nay = CW'(clamp_velocity(longint'(p.avy) - round_shift(ca * ny, NRM), o.satf));
      o.nbx = CW'(clamp_velocity(longint'(p.bvx) + round_shift(cb * nx, NRM), o.satf));
      o.nby = CW'(clamp_velocity(longint'(p.bvy) + round_shift(cb * ny, NRM), o.satf));
      return o;
   endfunction

   task automatic send_pair(input pair_type p);
      @(negedge clock);
      start = 1;
      req_a_pos_x = p.apx; req_a_pos_y = p.apy; req_b_pos_x = p.bpx; req_b_pos_y = p.bpy;
      req_a_vel_x = p.avx; req_a_vel_y = p.avy; req_b_vel_x = p.bvx; req_b_vel_y = p.bvy;
      req_a_mass = p.ma; req_b_mass = p.mb;
      req_a_restitution = p.ea; req_b_restitution = p.eb;
      do @(posedge clock); while (busy);
      pending_velocities = {pending_velocities, predict_impulse(p)};
      while ($urandom_range(99) < sender_idle_pct) begin
         @(negedge clock);
         start = 0;
      end
   endtask

   function automatic pair_type make_pair(input longint apx, apy, bpx, bpy, avx, avy, bvx, bvy,
                                          input int ma, mb, ea, eb);
      pair_type p;
      p.apx = CW'(apx); p.apy = CW'(apy); p.bpx = CW'(bpx); p.bpy = CW'(bpy);
      p.avx = CW'(avx); p.avy = CW'(avy); p.bvx = CW'(bvx); p.bvy = CW'(bvy);
      p.ma = MAW'(ma); p.mb = MAW'(mb); p.ea = EW'(ea); p.eb = EW'(eb);
      return p;
   endfunction

   function automatic logic signed [CW-1:0] random_coord(input int span);
      if ($urandom_range(3) == 0) return CW'($urandom);
      return CW'($signed($urandom_range(2 * span)) - span);
   endfunction

   task automatic test_extremes();
      longint mn, mxv;
      mn = -(longint'(1) << (CW - 1));
      mxv = (longint'(1) << (CW - 1)) - 1;
      send_pair(make_pair(mn, mn, mxv, mxv, mxv, mxv, mn, mn, 65535, 1, 256, 256));
      send_pair(make_pair(mxv, mxv, mn, mn, mn, mn, mxv, mxv, 1, 65535, 511, 511));
      send_pair(make_pair(0, 0, 256, 0, mxv, 0, mn, 0, 256, 256, 256, 256));
      send_pair(make_pair(0, 0, 0, 256, 0, mxv, 0, mn, 65535, 65535, 0, 0));
      send_pair(make_pair(0, 0, 1, 0, 512, 0, -512, 0, 256, 256, 128, 200));
      send_pair(make_pair(0, 0, 0, -1, 0, -300, 0, 300, 1, 1, 256, 0));
      send_pair(make_pair(mn, 0, mn + 3, 4, 1000, 1000, -1000, -1000, 300, 900, 100, 300));
   endtask

   task automatic test_special_cases();
      // coincident centers
      send_pair(make_pair(1234, -55, 1234, -55, 700, 800, -700, -800, 256, 256, 256, 256));
      send_pair(make_pair(-8, 9, -8, 9, 8388607, -8388608, 1, 2, 0, 0, 511, 0));
      // separating
      send_pair(make_pair(0, 0, 1000, 0, -500, 0, 500, 0, 256, 256, 256, 256));
      // zero normal speed
      send_pair(make_pair(0, 0, 700, 700, 40, 40, 40, 40, 256, 512, 256, 256));
      send_pair(make_pair(0, 0, 700, 0, 0, 90, 0, -90, 256, 256, 256, 256));
      // zero mass
      send_pair(make_pair(0, 0, 300, 400, 600, 800, 0, 0, 0, 256, 256, 256));
      send_pair(make_pair(0, 0, -300, 400, -600, 800, 0, 0, 512, 0, 200, 256));
      send_pair(make_pair(0, 0, 300, -400, 600, -800, 0, 0, 0, 0, 256, 256));
      // restitution above one
      send_pair(make_pair(0, 0, 500, 100, 900, 0, -900, 0, 256, 256, 300, 400));
      send_pair(make_pair(0, 0, 500, 100, 900, 0, -900, 0, 256, 256, 257, 511));
   endtask

   task automatic test_random_pairs(input int count, input int idle_pct);
      pair_type p;
      int span;
      sender_idle_pct = idle_pct;
      repeat (count) begin
         span = ($urandom_range(3) == 0) ? 8388607 : $urandom_range(1, 1 << $urandom_range(4, 20));
         p.apx = random_coord(span); p.apy = random_coord(span);
         p.bpx = ($urandom_range(9) == 0) ? p.apx : random_coord(span);
         p.bpy = ($urandom_range(9) == 0) ? p.apy : random_coord(span);
         p.avx = random_coord(span); p.avy = random_coord(span);
         p.bvx = random_coord(span); p.bvy = random_coord(span);
         // mostly approaching pairs
         if ($urandom_range(3) != 0) begin
            if ((p.bpx > p.apx) == (p.bvx > p.avx)) begin
               p.avx = p.bvx; p.bvx = random_coord(span);
            end
         end
         p.ma = ($urandom_range(7) == 0) ? MAW'($urandom) : MAW'($urandom_range(1, 4096));
         p.mb = ($urandom_range(7) == 0) ? MAW'($urandom) : MAW'($urandom_range(1, 4096));
         p.ea = ($urandom_range(7) == 0) ? EW'($urandom) : EW'($urandom_range(256));
         p.eb = ($urandom_range(7) == 0) ? EW'($urandom) : EW'($urandom_range(256));
         send_pair(p);
      end
      @(negedge clock);
      start = 0;
   endtask

   task automatic check_field(input string name, input longint want, input longint got);
      if (want != got) begin
         failures++;
         $display("%0t %s mismatch: expected %0d actual %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      velocities_type w;
      if (!reset && rsp_valid) begin
         if (pending_velocities.size() == 0) begin
            failures++;
            $display("%0t unexpected response: expected none actual %0d %0d %0d %0d", $time,
                     rsp_new_a_vel_x, rsp_new_a_vel_y, rsp_new_b_vel_x, rsp_new_b_vel_y);
         end else begin
            w = pending_velocities.pop_front();
            check_field("new_a_vel_x", w.nax, rsp_new_a_vel_x);
            check_field("new_a_vel_y", w.nay, rsp_new_a_vel_y);
            check_field("new_b_vel_x", w.nbx, rsp_new_b_vel_x);
            check_field("new_b_vel_y", w.nby, rsp_new_b_vel_y);
            check_field("impulse_applied", w.applied, rsp_impulse_applied);
            check_field("saturated", w.satf, rsp_saturated);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 0;
      sender_idle_pct = 13;
      test_extremes();
      test_special_cases();
      test_random_pairs(700, 13);
      test_random_pairs(700, 58);
      test_random_pairs(700, 0);
      while (pending_velocities.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
`default_nettype wire

@@ files.f @@
sv/cci_pkg.sv
sv/circle_collision_impulse.sv
sv/cci_checker.sv
bench/circle_collision_impulse_tb.sv
